>>> rtl/mhpq_pkg.sv
package mhpq_pkg;

   localparam int unsigned DefaultCapacity = 16;
   localparam int unsigned IdWidth         = 16;
   localparam int unsigned DoorsWidth      = 4;
   localparam int unsigned PriceWidth      = 32;
   localparam int unsigned SeriesWidth     = 8;
   localparam int unsigned RecWidth        = IdWidth + DoorsWidth + PriceWidth + SeriesWidth;

   localparam logic KindLoad    = 1'b0;
   localparam logic KindExtract = 1'b1;

   typedef struct packed {
      logic [IdWidth-1:0]     id;
      logic [DoorsWidth-1:0]  doors;
      logic [PriceWidth-1:0]  price;
      logic [SeriesWidth-1:0] series;
   } rec_type;

   // datapath operations driven by the controller
   typedef enum logic [3:0] {
      OP_NONE     = 4'd0,
      OP_LOAD     = 4'd1,
      OP_RB_INIT  = 4'd2,
      OP_RB_NEXT  = 4'd3,
      OP_RD_NODE  = 4'd4,
      OP_RD_LEFT  = 4'd5,
      OP_RD_RIGHT = 4'd6,
      OP_SWAP_A   = 4'd7,
      OP_SWAP_B   = 4'd8,
      OP_EX_INIT  = 4'd9,
      OP_EX_LAST  = 4'd10,
      OP_EX_WRITE = 4'd11,
      OP_EMPTY    = 4'd12,
      OP_SWAP_C   = 4'd13
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic built;
      logic rb_done;
      logic has_left;
      logic has_right;
      logic swap_needed;
   } status_type;

endpackage

>>> rtl/mhpq_datapath.sv
module mhpq_datapath #(
   parameter int unsigned CAPACITY = mhpq_pkg::DefaultCapacity,
   parameter int unsigned CntWidth = $clog2(CAPACITY + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mhpq_pkg::cmd_type    cmd,
   output mhpq_pkg::status_type status,
   input  mhpq_pkg::rec_type    load_rec,
   output mhpq_pkg::rec_type    top_rec,
   output logic [CntWidth-1:0]  count
);
   import mhpq_pkg::*;

   localparam int unsigned IdxWidth = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned PosWidth = CntWidth + 1;

   rec_type mem [CAPACITY];

   logic [CntWidth-1:0] count_ff, count_in;
   logic                built_ff, built_in;
   logic [CntWidth-1:0] rb_ff, rb_in;
   logic [PosWidth-1:0] pos_ff, pos_in;
   logic [PosWidth-1:0] best_ff, best_in;
   rec_type             node_ff, best_rec_ff, top_ff, rd_data_ff;
   rec_type             node_in, best_rec_in, top_in;
   logic                wr_en;
   logic [IdxWidth-1:0] wr_addr, rd_addr;
   rec_type             wr_data;
   logic [PosWidth-1:0] left_pos, right_pos;

   assign left_pos  = {pos_ff[PosWidth-2:0], 1'b1};
   assign right_pos = left_pos + PosWidth'(1);

   always_comb begin
      count_in    = count_ff;
      built_in    = built_ff;
      rb_in       = rb_ff;
      pos_in      = pos_ff;
      best_in     = best_ff;
      node_in     = node_ff;
      best_rec_in = best_rec_ff;
      top_in      = top_ff;
      wr_en       = 1'b0;
      wr_addr     = pos_ff[IdxWidth-1:0];
      wr_data     = node_ff;
      rd_addr     = pos_ff[IdxWidth-1:0];
      unique case (cmd.op)
         OP_LOAD: begin
            wr_en    = 1'b1;
            wr_addr  = count_ff[IdxWidth-1:0];
            wr_data  = load_rec;
            count_in = count_ff + CntWidth'(1);
            built_in = 1'b0;
         end
         OP_RB_INIT: begin
            rb_in    = count_ff >> 1;
            built_in = 1'b1;
         end
         OP_RB_NEXT: begin
            rb_in  = rb_ff - CntWidth'(1);
            pos_in = PosWidth'(rb_ff - CntWidth'(1));
         end
         OP_RD_NODE: rd_addr = pos_ff[IdxWidth-1:0];
         OP_RD_LEFT: begin
            // rd_data now holds the node
            node_in     = rd_data_ff;
            best_rec_in = rd_data_ff;
            best_in     = pos_ff;
            rd_addr     = left_pos[IdxWidth-1:0];
         end
         OP_RD_RIGHT: begin
            // rd_data holds the left child
            if (best_rec_ff.price < rd_data_ff.price) begin
               best_rec_in = rd_data_ff;
               best_in     = left_pos;
            end
            rd_addr = right_pos[IdxWidth-1:0];
         end
         OP_SWAP_A: begin
            if (best_rec_ff.price < rd_data_ff.price) begin
               best_rec_in = rd_data_ff;
               best_in     = right_pos;
            end
         end
         OP_SWAP_B: begin
            // parent slot takes the child, walk down
            wr_en   = 1'b1;
            wr_addr = pos_ff[IdxWidth-1:0];
            wr_data = best_rec_ff;
            pos_in  = best_ff;
         end
         OP_SWAP_C: begin
            // sifted node lands in the child slot
            wr_en   = 1'b1;
            wr_addr = pos_ff[IdxWidth-1:0];
            wr_data = node_ff;
         end
         OP_EX_INIT: begin
            rd_addr = count_ff[IdxWidth-1:0] - IdxWidth'(1);
            count_in = count_ff - CntWidth'(1);
         end
         OP_EX_LAST: begin
            node_in = rd_data_ff;
            rd_addr = '0;
         end
         OP_EX_WRITE: begin
            // rd_data holds root, node holds last record
            top_in  = rd_data_ff;
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = node_ff;
            pos_in  = '0;
         end
         OP_EMPTY: top_in = '0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         built_ff <= 1'b1;
      end else begin
         count_ff <= count_in;
         built_ff <= built_in;
      end
      rb_ff       <= rb_in;
      pos_ff      <= pos_in;
      best_ff     <= best_in;
      node_ff     <= node_in;
      best_rec_ff <= best_rec_in;
      top_ff      <= top_in;
   end

   assign status.full        = (count_ff == CntWidth'(CAPACITY));
   assign status.empty       = (count_ff == '0);
   assign status.built       = built_ff;
   assign status.rb_done     = (rb_ff == '0);
   assign status.has_left    = (left_pos < PosWidth'(count_ff));
   assign status.has_right   = (right_pos < PosWidth'(count_ff));
   assign status.swap_needed = (best_ff != pos_ff);
   assign top_rec = top_ff;
   assign count   = count_ff;
endmodule

>>> rtl/mhpq_ctrl.sv
module mhpq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_kind,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_found,
   output mhpq_pkg::cmd_type    cmd,
   input  mhpq_pkg::status_type status
);
   import mhpq_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_RB     = 11'b00000000010,
      S_RD     = 11'b00000000100,
      S_RL     = 11'b00000001000,
      S_RR     = 11'b00000010000,
      S_CMP    = 11'b00000100000,
      S_SWB    = 11'b00001000000,
      S_SWC    = 11'b00010000000,
      S_EXA    = 11'b00100000000,
      S_EXB    = 11'b01000000000,
      S_OUT    = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rebuild_ff, rebuild_in;
   logic      found_ff, found_in;

   assign req_stall = (state_ff != S_IDLE) || rsp_valid;

   always_comb begin
      state_in   = state_ff;
      rebuild_in = rebuild_ff;
      found_in   = found_ff;
      cmd.op     = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !rsp_valid) begin
               if (req_kind == KindLoad) begin
                  if (!status.full) cmd.op = OP_LOAD;
               end else if (!status.built) begin
                  cmd.op     = OP_RB_INIT;
                  rebuild_in = 1'b1;
                  state_in   = S_RB;
               end else if (status.empty) begin
                  cmd.op   = OP_EMPTY;
                  found_in = 1'b0;
                  state_in = S_OUT;
               end else begin
                  cmd.op   = OP_EX_INIT;
                  state_in = S_EXA;
               end
            end
         end
         S_RB: begin
            if (status.rb_done) begin
               rebuild_in = 1'b0;
               if (status.empty) begin
                  cmd.op   = OP_EMPTY;
                  found_in = 1'b0;
                  state_in = S_OUT;
               end else begin
                  cmd.op   = OP_EX_INIT;
                  state_in = S_EXA;
               end
            end else begin
               cmd.op   = OP_RB_NEXT;
               state_in = S_RD;
            end
         end
         S_RD: begin
            cmd.op   = OP_RD_NODE;
            state_in = S_RL;
         end
         S_RL: begin
            cmd.op   = OP_RD_LEFT;
            state_in = S_RR;
         end
         S_RR: begin
            if (status.has_left) begin
               cmd.op   = OP_RD_RIGHT;
               state_in = S_CMP;
            end else begin
               state_in = rebuild_ff ? S_RB : S_OUT;
               found_in = 1'b1;
            end
         end
         S_CMP: begin
            if (status.has_right) cmd.op = OP_SWAP_A;
            state_in = S_SWB;
         end
         S_SWB: begin
            if (status.swap_needed) begin
               cmd.op   = OP_SWAP_B;
               state_in = S_SWC;
            end else begin
               state_in = rebuild_ff ? S_RB : S_OUT;
               found_in = 1'b1;
            end
         end
         S_SWC: begin
            // node value goes into the child slot
            cmd.op   = OP_SWAP_C;
            state_in = S_RD;
         end
         S_EXA: begin
            cmd.op   = OP_EX_LAST;
            state_in = S_EXB;
         end
         S_EXB: begin
            cmd.op   = OP_EX_WRITE;
            state_in = S_RD;
         end
         S_OUT: begin
            if (!rsp_stall || !rsp_valid) state_in = S_OUT;
            if (rsp_valid && !rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_found = found_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         rebuild_ff <= 1'b0;
         found_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rebuild_ff <= rebuild_in;
         found_ff   <= found_in;
      end
   end
endmodule

>>> rtl/max_heap_priority_queue.sv
// Binary max-heap of up to CAPACITY records keyed on price. A load into a
// full store is dropped. An extract on an empty heap answers on the next
// cycle. Otherwise an extract first rebuilds the heap if loads came since
// the last extract, sifting down the first count/2 stored nodes, last first,
// then takes the root and sifts down; the entry memory has a single read
// port. One request is worked on at a time; the result is held until taken.
module max_heap_priority_queue #(
   parameter int unsigned CAPACITY = mhpq_pkg::DefaultCapacity
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_kind,
   input  logic [mhpq_pkg::IdWidth-1:0]        req_rec_id,
   input  logic [mhpq_pkg::DoorsWidth-1:0]     req_door_count,
   input  logic [mhpq_pkg::PriceWidth-1:0]     req_price,
   input  logic [mhpq_pkg::SeriesWidth-1:0]    req_series_code,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_found,
   output logic [mhpq_pkg::IdWidth-1:0]        rsp_out_id,
   output logic [mhpq_pkg::DoorsWidth-1:0]     rsp_out_doors,
   output logic [mhpq_pkg::PriceWidth-1:0]     rsp_out_price,
   output logic [mhpq_pkg::SeriesWidth-1:0]    rsp_out_series,
   output logic [4:0]                          rsp_remaining
);
   import mhpq_pkg::*;

   localparam int unsigned CntWidth = $clog2(CAPACITY + 1);

   cmd_type             cmd;
   status_type          status;
   rec_type             load_rec, top_rec;
   logic [CntWidth-1:0] count;

   assign load_rec = '{id: req_rec_id, doors: req_door_count,
                       price: req_price, series: req_series_code};

   mhpq_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_kind,
      .rsp_valid, .rsp_stall, .rsp_found, .cmd, .status
   );

   mhpq_datapath #(.CAPACITY(CAPACITY), .CntWidth(CntWidth)) u_dp (
      .clock, .reset, .cmd, .status, .load_rec, .top_rec, .count
   );

   assign rsp_out_id     = top_rec.id;
   assign rsp_out_doors  = top_rec.doors;
   assign rsp_out_price  = top_rec.price;
   assign rsp_out_series = top_rec.series;
   assign rsp_remaining  = rsp_found ? 5'(count) : 5'd0;
endmodule

>>> rtl/mhpq_checker.sv
module mhpq_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_found,
   input logic [4:0] rsp_remaining,
   input logic [31:0] rsp_out_price
);
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken while result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_price))
      else $error("result dropped");
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_remaining == 5'd0) else $error("empty result count");
endmodule

bind max_heap_priority_queue mhpq_checker u_chk (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_found, .rsp_remaining, .rsp_out_price
);

>>> test/testbench.sv
module testbench;
   import mhpq_pkg::*;

   localparam int unsigned Capacity = DefaultCapacity;
   localparam int unsigned CycleLimit = 2000000;

   typedef struct packed {
      logic                   found;
      logic [IdWidth-1:0]     id;
      logic [DoorsWidth-1:0]  doors;
      logic [PriceWidth-1:0]  price;
      logic [SeriesWidth-1:0] series;
      logic [4:0]             remaining;
   } pick_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_kind = KindLoad;
   logic [IdWidth-1:0] req_rec_id = '0;
   logic [DoorsWidth-1:0] req_door_count = '0;
   logic [PriceWidth-1:0] req_price = '0;
   logic [SeriesWidth-1:0] req_series_code = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_found;
   logic [IdWidth-1:0] rsp_out_id;
   logic [DoorsWidth-1:0] rsp_out_doors;
   logic [PriceWidth-1:0] rsp_out_price;
   logic [SeriesWidth-1:0] rsp_out_series;
   logic [4:0] rsp_remaining;

   // predictor state
   rec_type heap_slots [Capacity];
   int unsigned heap_size = 0;
   bit heap_ok = 1'b1;
   pick_type pending_picks [$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   max_heap_priority_queue dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("max_heap_priority_queue regression: fail");
         $finish;
      end
   end

   task automatic report(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   function automatic void sift_from(input int unsigned start);
      int unsigned pos;
      int unsigned best;
      rec_type t;
      pos = start;
      while (pos < heap_size) begin
         best = pos;
         if (2 * pos + 1 < heap_size && heap_slots[best].price < heap_slots[2 * pos + 1].price)
            best = 2 * pos + 1;
         if (2 * pos + 2 < heap_size && heap_slots[best].price < heap_slots[2 * pos + 2].price)
            best = 2 * pos + 2;
         if (best == pos) break;
         t = heap_slots[best];
         heap_slots[best] = heap_slots[pos];
         heap_slots[pos] = t;
         pos = best;
      end
   endfunction

   function automatic void predict(input logic kind, input rec_type r);
      pick_type p;
      rec_type t;
      p = '0;
      if (kind == KindLoad) begin
         if (heap_size < Capacity) begin
            heap_slots[heap_size] = r;
            heap_size++;
            heap_ok = 1'b0;
         end
         return;
      end
      if (!heap_ok) begin
         for (int i = int'(heap_size / 2) - 1; i >= 0; i--) sift_from(i);
         heap_ok = 1'b1;
      end
      if (heap_size != 0) begin
         t = heap_slots[0];
         heap_slots[0] = heap_slots[heap_size - 1];
         heap_slots[heap_size - 1] = t;
         heap_size--;
         sift_from(0);
         p.found = 1'b1;
         p.id = t.id;
         p.doors = t.doors;
         p.price = t.price;
         p.series = t.series;
         p.remaining = heap_size[4:0];
      end
      pending_picks.push_back(p);
   endfunction

   // sends one request after a random gap; valid stays up when no gap follows
   task automatic send(input logic kind, input rec_type r);
      int unsigned gap;
      gap = $urandom_range(0, 4);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_rec_id <= r.id;
      req_door_count <= r.doors;
      req_price <= r.price;
      req_series_code <= r.series;
      do @(posedge clock); while (req_stall);
      predict(kind, r);
   endtask

   task automatic load_rec(input logic [PriceWidth-1:0] price);
      rec_type r;
      r.id = IdWidth'($urandom);
      r.doors = DoorsWidth'($urandom);
      r.price = price;
      r.series = SeriesWidth'($urandom);
      send(KindLoad, r);
   endtask

   task automatic extract();
      rec_type r;
      r = RecWidth'({$urandom, $urandom});
      send(KindExtract, r);
   endtask

   function automatic logic [PriceWidth-1:0] rand_price();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 3);
         1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   // result checker
   always @(posedge clock) begin
      pick_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_picks.size() == 0) begin
            report("unexpected response");
         end else begin
            want = pending_picks.pop_front();
            if (rsp_found !== want.found) report("found");
            if (rsp_out_id !== want.id) report("out_id");
            if (rsp_out_doors !== want.doors) report("out_doors");
            if (rsp_out_price !== want.price) report("out_price");
            if (rsp_out_series !== want.series) report("out_series");
            if (rsp_remaining !== want.remaining) report("remaining");
         end
      end
   end

   // response stall: random hold per response, with calm stretches
   initial begin
      int unsigned waits;
      forever begin
         @(negedge clock);
         if (cycle_count % 4000 < 800) begin
            rsp_stall <= 1'b0;
         end else begin
            waits = $urandom_range(0, 4);
            if (waits != 0) begin
               rsp_stall <= 1'b1;
               repeat (waits) @(negedge clock);
            end
            rsp_stall <= 1'b0;
            do @(negedge clock); while (!rsp_valid);
         end
      end
   end

   task automatic test_empty();
      extract();
      extract();
   endtask

   task automatic test_extremes();
      rec_type r;
      r = '1;
      send(KindLoad, r);
      r = '0;
      send(KindLoad, r);
      load_rec(32'h8000_0000);
      load_rec(32'h8000_0000);
      load_rec(32'h8000_0000);
      repeat (6) extract();
   endtask

   task automatic test_full();
      repeat (Capacity + 2) load_rec(rand_price());
      repeat (3) extract();
      load_rec(rand_price());
      repeat (Capacity) extract();
   endtask

   task automatic test_random();
      for (int n = 0; n < 1000; n++) begin
         if ($urandom_range(0, 99) < (heap_size < 4 ? 70 : (heap_size > 13 ? 25 : 50)))
            load_rec(rand_price());
         else
            extract();
      end
      while (heap_size != 0) extract();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty();
      test_extremes();
      test_full();
      test_random();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_picks.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (error_count == 0 && pending_picks.size() == 0)
         $display("max_heap_priority_queue regression: pass");
      else
         $display("max_heap_priority_queue regression: fail");
      $finish;
   end

endmodule

>>> sim.f
rtl/mhpq_pkg.sv
rtl/mhpq_datapath.sv
rtl/mhpq_ctrl.sv
rtl/max_heap_priority_queue.sv
rtl/mhpq_checker.sv
test/testbench.sv
